[sv/obd_pkg.sv]
// Shared types, widths and constants for the orthonormal basis unit.
package obd_pkg;

  localparam int FRAC_BITS = 14;
  localparam int GUARD     = 8;

  localparam int DIR_W  = 16;
  localparam int MAG_W  = DIR_W + 1;
  localparam int SQ_W   = 2 * DIR_W;
  localparam int RAD_W  = SQ_W + 2 * GUARD;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int NUM_SH = FRAC_BITS + GUARD + 1;
  localparam int DIV_W  = MAG_W + NUM_SH + 1;
  localparam int DEN_W  = ROOT_W + 1;
  localparam int PROD_W = 2 * DIR_W;
  localparam int RND_W  = PROD_W + 2;

  // entry(1) + square(1) + sum(1) + root + divide setup(1) + quotient + tangent(1) + cross(2)
  localparam int LATENCY = 7 + ROOT_W + QUO_W;

  // 0.57735 in fixed point, rounded to nearest
  localparam logic [63:0] THRESH =
    (64'd57735 * (64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;

  typedef logic signed [DIR_W-1:0] comp_t;
  typedef logic [MAG_W-1:0]        mag_t;

  localparam comp_t COMP_MAX = {1'b0, {(DIR_W-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(DIR_W-1){1'b0}}};

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
  } vec_t;

  // Sideband that rides along the root and divide pipes
  typedef struct packed {
    vec_t dir;
    logic sel_x;   // tangent built from x: (y, -x, 0)
    logic neg_a;
    logic neg_b;
    logic degen;
    mag_t mag_a;
    mag_t mag_b;
  } side_t;

endpackage

[sv/obd_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module obd_sqrt import obd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_rad,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output side_t             out_side
);

  logic [ROOT_W-1:0] vld_r;
  logic [ROOT_W-1:0] vld_nxt;
  logic [REM_W-1:0]  rem_r   [0:ROOT_W-2];
  logic [REM_W-1:0]  rem_nxt [0:ROOT_W-2];
  logic [RAD_W-1:0]  rad_r   [0:ROOT_W-2];
  logic [RAD_W-1:0]  rad_nxt [0:ROOT_W-2];
  logic [ROOT_W-1:0] root_r   [0:ROOT_W-1];
  logic [ROOT_W-1:0] root_nxt [0:ROOT_W-1];
  side_t             side_r  [0:ROOT_W-1];

  function automatic logic [REM_W+ROOT_W-1:0] sqrt_step(input logic [REM_W-1:0] rem_p,
                                                       input logic [1:0] pair,
                                                       input logic [ROOT_W-1:0] root_p);
    logic [REM_W-1:0] rem_s;
    logic [REM_W-1:0] trial;
    rem_s = {rem_p[REM_W-3:0], pair};
    trial = REM_W'({root_p, 2'b01});
    if (rem_s >= trial) begin
      sqrt_step = {rem_s - trial, root_p[ROOT_W-2:0], 1'b1};
    end else begin
      sqrt_step = {rem_s, root_p[ROOT_W-2:0], 1'b0};
    end
  endfunction

  always_comb begin
    logic [REM_W+ROOT_W-1:0] step;
    vld_nxt = {vld_r[ROOT_W-2:0], in_valid};

    step = sqrt_step('0, in_rad[RAD_W-1 -: 2], '0);
    rem_nxt[0]  = step[REM_W+ROOT_W-1:ROOT_W];
    root_nxt[0] = step[ROOT_W-1:0];
    rad_nxt[0]  = in_rad << 2;

    for (int k = 1; k < ROOT_W - 1; k++) begin
      step = sqrt_step(rem_r[k-1], rad_r[k-1][RAD_W-1 -: 2], root_r[k-1]);
      rem_nxt[k]  = step[REM_W+ROOT_W-1:ROOT_W];
      root_nxt[k] = step[ROOT_W-1:0];
      rad_nxt[k]  = rad_r[k-1] << 2;
    end

    step = sqrt_step(rem_r[ROOT_W-2], rad_r[ROOT_W-2][RAD_W-1 -: 2], root_r[ROOT_W-2]);
    root_nxt[ROOT_W-1] = step[ROOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int k = 0; k < ROOT_W - 1; k++) begin
      rem_r[k] <= rem_nxt[k];
      rad_r[k] <= rad_nxt[k];
    end
    for (int k = 0; k < ROOT_W; k++) begin
      root_r[k] <= root_nxt[k];
    end
    for (int k = 1; k < ROOT_W; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule

[sv/obd_div.sv]
// Two-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
module obd_div import obd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [DIV_W-1:0] in_num_a,
  input  logic [DIV_W-1:0] in_num_b,
  input  logic [DEN_W-1:0] in_den,
  input  side_t            in_side,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo_a,
  output logic [QUO_W-1:0] out_quo_b,
  output side_t            out_side
);

  logic [QUO_W-1:0] vld_r;
  logic [QUO_W-1:0] vld_nxt;
  logic [DIV_W-1:0] rem_r   [0:QUO_W-2][0:1];
  logic [DIV_W-1:0] rem_nxt [0:QUO_W-2][0:1];
  logic [QUO_W-1:0] quo_r   [0:QUO_W-1][0:1];
  logic [QUO_W-1:0] quo_nxt [0:QUO_W-1][0:1];
  logic [DEN_W-1:0] den_r   [0:QUO_W-2];
  side_t            side_r  [0:QUO_W-1];

  function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                               input logic [DEN_W-1:0] den,
                                               input int sh);
    logic [DIV_W-1:0] sub;
    sub = DIV_W'(den) << sh;
    if (rem >= sub) begin
      div_step = {rem - sub, 1'b1};
    end else begin
      div_step = {rem, 1'b0};
    end
  endfunction

  always_comb begin
    logic [DIV_W:0] step;
    vld_nxt = {vld_r[QUO_W-2:0], in_valid};

    step = div_step(in_num_a, in_den, QUO_W - 1);
    rem_nxt[0][0] = step[DIV_W:1];
    quo_nxt[0][0] = QUO_W'(step[0]);
    step = div_step(in_num_b, in_den, QUO_W - 1);
    rem_nxt[0][1] = step[DIV_W:1];
    quo_nxt[0][1] = QUO_W'(step[0]);

    for (int k = 1; k < QUO_W - 1; k++) begin
      for (int l = 0; l < 2; l++) begin
        step = div_step(rem_r[k-1][l], den_r[k-1], QUO_W - 1 - k);
        rem_nxt[k][l] = step[DIV_W:1];
        quo_nxt[k][l] = {quo_r[k-1][l][QUO_W-2:0], step[0]};
      end
    end

    for (int l = 0; l < 2; l++) begin
      step = div_step(rem_r[QUO_W-2][l], den_r[QUO_W-2], 0);
      quo_nxt[QUO_W-1][l] = {quo_r[QUO_W-2][l][QUO_W-2:0], step[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r[0]  <= in_den;
    side_r[0] <= in_side;
    for (int k = 1; k < QUO_W - 1; k++) begin
      den_r[k] <= den_r[k-1];
    end
    for (int k = 1; k < QUO_W; k++) begin
      side_r[k] <= side_r[k-1];
    end
    for (int k = 0; k < QUO_W - 1; k++) begin
      for (int l = 0; l < 2; l++) begin
        rem_r[k][l] <= rem_nxt[k][l];
      end
    end
    for (int k = 0; k < QUO_W; k++) begin
      for (int l = 0; l < 2; l++) begin
        quo_r[k][l] <= quo_nxt[k][l];
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_quo_a = quo_r[QUO_W-1][0];
  assign out_quo_b = quo_r[QUO_W-1][1];
  assign out_side  = side_r[QUO_W-1];

endmodule

[sv/obd_cross.sv]
// Cross product of direction and first tangent, rounded and saturated; two stages.
module obd_cross import obd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  vec_t in_dir,
  input  vec_t in_tan,
  input  logic in_degen,
  output logic out_valid,
  output vec_t out_tan1,
  output vec_t out_tan2,
  output logic out_degen
);

  logic                     a_valid_r;
  vec_t                     a_tan_r;
  logic                     a_degen_r;
  logic signed [PROD_W-1:0] prod_r   [0:5];
  logic signed [PROD_W-1:0] prod_nxt [0:5];

  logic valid_r;
  vec_t tan1_r;
  vec_t tan2_r;
  vec_t tan2_nxt;
  logic degen_r;

  function automatic comp_t round_sat(input logic signed [PROD_W-1:0] p,
                                      input logic signed [PROD_W-1:0] q);
    logic [RND_W-1:0]        rnd;
    logic signed [RND_W-1:0] w;
    logic signed [RND_W-1:0] s;
    rnd = RND_W'(1) << (FRAC_BITS - 1);
    w = RND_W'(p) - RND_W'(q) + rnd;
    s = w >>> FRAC_BITS;
    if (!s[RND_W-1] && (s[RND_W-2:DIR_W-1] != '0)) begin
      round_sat = COMP_MAX;
    end else if (s[RND_W-1] && (s[RND_W-2:DIR_W-1] != '1)) begin
      round_sat = COMP_MIN;
    end else begin
      round_sat = s[DIR_W-1:0];
    end
  endfunction

  always_comb begin
    prod_nxt[0] = in_dir.y * in_tan.z;
    prod_nxt[1] = in_dir.z * in_tan.y;
    prod_nxt[2] = in_dir.z * in_tan.x;
    prod_nxt[3] = in_dir.x * in_tan.z;
    prod_nxt[4] = in_dir.x * in_tan.y;
    prod_nxt[5] = in_dir.y * in_tan.x;
  end

  always_comb begin
    tan2_nxt.x = round_sat(prod_r[0], prod_r[1]);
    tan2_nxt.y = round_sat(prod_r[2], prod_r[3]);
    tan2_nxt.z = round_sat(prod_r[4], prod_r[5]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      valid_r   <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      prod_r[i] <= prod_nxt[i];
    end
    a_tan_r   <= in_tan;
    a_degen_r <= in_degen;
    tan1_r    <= a_tan_r;
    tan2_r    <= tan2_nxt;
    degen_r   <= a_degen_r;
  end

  assign out_valid = valid_r;
  assign out_tan1  = tan1_r;
  assign out_tan2  = tan2_r;
  assign out_degen = degen_r;

endmodule

[sv/orthonormal_basis_from_direction_unit.sv]
// Top level: orthonormal frame (two unit tangents) from a Q2.14 direction vector.
//
// Takes one direction per clock (start while busy is low; busy never rises) and returns
// the two tangents and the degenerate flag on out_valid, in order, one result per item.
// The pipeline is the 24-stage square root (one root bit per stage) and the 15-stage
// divider (one quotient bit per stage), plus seven stages for entry, squaring, summing,
// divider setup, tangent formatting and the two cross-product stages. The output cannot
// be stalled: each result is shown for exactly one cycle and must be taken then.
module orthonormal_basis_from_direction_unit import obd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  comp_t in_dir_x,
  input  comp_t in_dir_y,
  input  comp_t in_dir_z,
  output logic  out_valid,
  output comp_t out_tan1_x,
  output comp_t out_tan1_y,
  output comp_t out_tan1_z,
  output comp_t out_tan2_x,
  output comp_t out_tan2_y,
  output comp_t out_tan2_z,
  output logic  out_degenerate
);

  localparam logic [QUO_W-1:0] ONE     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [63:0]      POS_LIM = 64'((64'd1 << (DIR_W - 1)) - 64'd1);
  localparam logic [63:0]      NEG_LIM = 64'd1 << (DIR_W - 1);

  logic in_fire;

  // entry
  logic                    s1_valid_r;
  side_t                   s1_side_r;
  side_t                   s1_side_nxt;
  logic signed [MAG_W-1:0] dx_e, dy_e, dz_e, a_e, b_e;
  mag_t                    ax;

  // squares
  logic            s2_valid_r;
  side_t           s2_side_r;
  logic [SQ_W-1:0] sqa_r, sqb_r;

  // sum
  logic             s3_valid_r;
  side_t            s3_side_r;
  side_t            s3_side_nxt;
  logic [SQ_W-1:0]  sq_sum;
  logic [RAD_W-1:0] rad_r;

  // root
  logic              rt_valid;
  logic [ROOT_W-1:0] rt_root;
  side_t             rt_side;

  // divider setup
  logic             p_valid_r;
  side_t            p_side_r;
  logic [DIV_W-1:0] num_a_r, num_b_r;
  logic [DEN_W-1:0] den_r;

  // quotient
  logic             dv_valid;
  logic [QUO_W-1:0] dv_quo_a, dv_quo_b;
  side_t            dv_side;

  // tangent formatting
  logic  tf_valid_r;
  vec_t  tf_dir_r;
  vec_t  tf_tan_r;
  vec_t  tf_tan_nxt;
  logic  tf_degen_r;
  comp_t ta, tb;

  // cross product
  logic cx_valid;
  vec_t cx_tan1, cx_tan2;
  logic cx_degen;

  function automatic comp_t tan_value(input logic [QUO_W-1:0] q, input logic neg);
    logic [QUO_W-1:0] qc;
    qc = (q > ONE) ? ONE : q;
    if (!neg) begin
      tan_value = (64'(qc) > POS_LIM) ? COMP_MAX : comp_t'(qc);
    end else begin
      tan_value = (64'(qc) > NEG_LIM) ? COMP_MIN : -comp_t'(qc);
    end
  endfunction

  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  // Pick the raw tangent: (y, -x, 0) when |x| is large, else (0, z, -y).
  always_comb begin
    dx_e = MAG_W'(in_dir_x);
    dy_e = MAG_W'(in_dir_y);
    dz_e = MAG_W'(in_dir_z);
    ax   = dx_e[MAG_W-1] ? mag_t'(-dx_e) : mag_t'(dx_e);
    s1_side_nxt       = '0;
    s1_side_nxt.dir.x = in_dir_x;
    s1_side_nxt.dir.y = in_dir_y;
    s1_side_nxt.dir.z = in_dir_z;
    s1_side_nxt.sel_x = (64'(ax) >= THRESH);
    a_e = s1_side_nxt.sel_x ? dy_e : dz_e;
    b_e = s1_side_nxt.sel_x ? -dx_e : -dy_e;
    s1_side_nxt.neg_a = a_e[MAG_W-1];
    s1_side_nxt.neg_b = b_e[MAG_W-1];
    s1_side_nxt.mag_a = a_e[MAG_W-1] ? mag_t'(-a_e) : mag_t'(a_e);
    s1_side_nxt.mag_b = b_e[MAG_W-1] ? mag_t'(-b_e) : mag_t'(b_e);
  end

  always_comb begin
    sq_sum            = sqa_r + sqb_r;
    s3_side_nxt       = s2_side_r;
    s3_side_nxt.degen = (sq_sum == '0);
  end

  always_comb begin
    ta = tan_value(dv_quo_a, dv_side.neg_a);
    tb = tan_value(dv_quo_b, dv_side.neg_b);
    if (dv_side.degen) begin
      tf_tan_nxt = '0;
    end else if (dv_side.sel_x) begin
      tf_tan_nxt.x = ta;
      tf_tan_nxt.y = tb;
      tf_tan_nxt.z = '0;
    end else begin
      tf_tan_nxt.x = '0;
      tf_tan_nxt.y = ta;
      tf_tan_nxt.z = tb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      p_valid_r  <= 1'b0;
      tf_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      p_valid_r  <= rt_valid;
      tf_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_side_r  <= s1_side_nxt;
    s2_side_r  <= s1_side_r;
    sqa_r      <= SQ_W'(s1_side_r.mag_a) * SQ_W'(s1_side_r.mag_a);
    sqb_r      <= SQ_W'(s1_side_r.mag_b) * SQ_W'(s1_side_r.mag_b);
    s3_side_r  <= s3_side_nxt;
    rad_r      <= {sq_sum, {(2*GUARD){1'b0}}};
    p_side_r   <= rt_side;
    num_a_r    <= (DIV_W'(rt_side.mag_a) << NUM_SH) + DIV_W'(rt_root);
    num_b_r    <= (DIV_W'(rt_side.mag_b) << NUM_SH) + DIV_W'(rt_root);
    den_r      <= {rt_root, 1'b0};
    tf_dir_r   <= dv_side.dir;
    tf_tan_r   <= tf_tan_nxt;
    tf_degen_r <= dv_side.degen;
  end

  obd_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_valid_r),
    .in_rad    (rad_r),
    .in_side   (s3_side_r),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  obd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_valid_r),
    .in_num_a  (num_a_r),
    .in_num_b  (num_b_r),
    .in_den    (den_r),
    .in_side   (p_side_r),
    .out_valid (dv_valid),
    .out_quo_a (dv_quo_a),
    .out_quo_b (dv_quo_b),
    .out_side  (dv_side)
  );

  obd_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tf_valid_r),
    .in_dir    (tf_dir_r),
    .in_tan    (tf_tan_r),
    .in_degen  (tf_degen_r),
    .out_valid (cx_valid),
    .out_tan1  (cx_tan1),
    .out_tan2  (cx_tan2),
    .out_degen (cx_degen)
  );

  assign out_valid      = cx_valid;
  assign out_tan1_x     = cx_tan1.x;
  assign out_tan1_y     = cx_tan1.y;
  assign out_tan1_z     = cx_tan1.z;
  assign out_tan2_x     = cx_tan2.x;
  assign out_tan2_y     = cx_tan2.y;
  assign out_tan2_z     = cx_tan2.z;
  assign out_degenerate = cx_degen;

  // every result traces back to an item taken a fixed number of edges earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && rst_n, LATENCY))
    else $error("result without an item taken LATENCY edges earlier");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_tan1_x == '0 && out_tan1_y == '0 && out_tan1_z == '0 &&
       out_tan2_x == '0 && out_tan2_y == '0 && out_tan2_z == '0))
    else $error("degenerate result with nonzero tangent");

  a_degen_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      $past(in_dir_y == '0 && in_dir_z == '0, LATENCY))
    else $error("degenerate flag on an item with nonzero y or z");

  a_tan1_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_degenerate) |-> (out_tan1_x == '0 || out_tan1_z == '0))
    else $error("first tangent has no zero component");

endmodule

[sim/obd_frame_checker.sv]
// Frame checker: predicts the tangent pair for each accepted direction and compares results.
module obd_frame_checker import obd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  busy,
  input  comp_t in_dir_x,
  input  comp_t in_dir_y,
  input  comp_t in_dir_z,
  input  logic  out_valid,
  input  comp_t out_tan1_x,
  input  comp_t out_tan1_y,
  input  comp_t out_tan1_z,
  input  comp_t out_tan2_x,
  input  comp_t out_tan2_y,
  input  comp_t out_tan2_z,
  input  logic  out_degenerate,
  output int    mismatches,
  output int    frames_pending
);

  typedef struct packed {
    comp_t t1x;
    comp_t t1y;
    comp_t t1z;
    comp_t t2x;
    comp_t t2y;
    comp_t t2z;
    logic  degen;
  } frame_t;

  frame_t frames_due[$];
  int     frames_seen;

  initial begin
    mismatches     = 0;
    frames_pending = 0;
    frames_seen    = 0;
  end

  function automatic longint clamp_comp(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic frame_t predict_frame(comp_t dx, comp_t dy, comp_t dz);
    longint sx, sy, sz, ax;
    longint raw [3];
    longint tn [3];
    longint cr [3];
    longint unsigned sq, rad, root, bitv, mag, num, q;
    frame_t f;
    sx = dx;
    sy = dy;
    sz = dz;
    ax = (sx < 0) ? -sx : sx;
    if (longint'(ax) >= longint'(THRESH)) begin
      raw[0] = sy; raw[1] = -sx; raw[2] = 0;
    end else begin
      raw[0] = 0; raw[1] = sz; raw[2] = -sy;
    end
    sq = raw[0] * raw[0] + raw[1] * raw[1] + raw[2] * raw[2];
    f = '0;
    if (sq == 0) begin
      f.degen = 1'b1;
      return f;
    end
    // bitwise integer square root of the length squared with guard bits
    rad  = sq << (2 * GUARD);
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rad) bitv >>= 2;
    while (bitv != 0) begin
      if (rad >= root + bitv) begin
        rad  = rad - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (root == 0) root = 1;
    // normalize: round half away from zero, capped at 1.0
    for (int i = 0; i < 3; i++) begin
      mag = (raw[i] < 0) ? -raw[i] : raw[i];
      num = mag << (FRAC_BITS + GUARD + 1);
      q   = (num + root) / (root << 1);
      if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
      tn[i] = clamp_comp((raw[i] < 0) ? -longint'(q) : longint'(q));
    end
    // cross(d, t1), rounded half up back to the fixed-point scale
    cr[0] = (sy * tn[2] - sz * tn[1] + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    cr[1] = (sz * tn[0] - sx * tn[2] + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    cr[2] = (sx * tn[1] - sy * tn[0] + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    f.t1x = comp_t'(tn[0]);
    f.t1y = comp_t'(tn[1]);
    f.t1z = comp_t'(tn[2]);
    f.t2x = comp_t'(clamp_comp(cr[0]));
    f.t2y = comp_t'(clamp_comp(cr[1]));
    f.t2z = comp_t'(clamp_comp(cr[2]));
    return f;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 100) $display("frame %0d: %s", frames_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(string fname, int got, int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", fname, got, want));
  endtask

  always @(posedge clk) begin
    frame_t want;
    if (!rst_n) begin
      frames_due.delete();
    end else begin
      if (start && !busy) frames_due.push_back(predict_frame(in_dir_x, in_dir_y, in_dir_z));
      if (out_valid) begin
        if (frames_due.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = frames_due.pop_front();
          check_field("tan1_x", out_tan1_x, want.t1x);
          check_field("tan1_y", out_tan1_y, want.t1y);
          check_field("tan1_z", out_tan1_z, want.t1z);
          check_field("tan2_x", out_tan2_x, want.t2x);
          check_field("tan2_y", out_tan2_y, want.t2y);
          check_field("tan2_z", out_tan2_z, want.t2z);
          check_field("degenerate", out_degenerate, want.degen);
        end
        frames_seen++;
      end
    end
    frames_pending <= frames_due.size();
  end

endmodule

[sim/orthonormal_basis_from_direction_unit_tb.sv]
// Testbench top: drives directions into the orthonormal basis unit and gives the verdict.
module orthonormal_basis_from_direction_unit_tb import obd_pkg::*; ;

  localparam int RAND_ITEMS = 900;
  localparam int CALM_TAIL  = 150;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  comp_t in_dir_x = '0;
  comp_t in_dir_y = '0;
  comp_t in_dir_z = '0;
  logic  out_valid;
  comp_t out_tan1_x, out_tan1_y, out_tan1_z;
  comp_t out_tan2_x, out_tan2_y, out_tan2_z;
  logic  out_degenerate;
  int    mismatches;
  int    frames_pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  orthonormal_basis_from_direction_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .out_valid(out_valid),
    .out_tan1_x(out_tan1_x), .out_tan1_y(out_tan1_y), .out_tan1_z(out_tan1_z),
    .out_tan2_x(out_tan2_x), .out_tan2_y(out_tan2_y), .out_tan2_z(out_tan2_z),
    .out_degenerate(out_degenerate)
  );

  obd_frame_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .out_valid(out_valid),
    .out_tan1_x(out_tan1_x), .out_tan1_y(out_tan1_y), .out_tan1_z(out_tan1_z),
    .out_tan2_x(out_tan2_x), .out_tan2_y(out_tan2_y), .out_tan2_z(out_tan2_z),
    .out_degenerate(out_degenerate),
    .mismatches(mismatches), .frames_pending(frames_pending)
  );

  // Called at a rising edge; returns just after the edge that took the item.
  task automatic send_dir(int x, int y, int z);
    in_dir_x <= comp_t'(x);
    in_dir_y <= comp_t'(y);
    in_dir_z <= comp_t'(z);
    start    <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
  endtask

  function automatic int rand_comp();
    return int'($urandom_range(32768)) - 16384;
  endfunction

  // random direction scaled to unit length in Q2.14
  task automatic send_unit_dir;
    real vx, vy, vz, len;
    vx  = real'($urandom_range(2000000)) - 1000000.0;
    vy  = real'($urandom_range(2000000)) - 1000000.0;
    vz  = real'($urandom_range(2000000)) - 1000000.0;
    len = $sqrt(vx * vx + vy * vy + vz * vz);
    if (len < 1.0) begin
      vx = 1.0; len = 1.0;
    end
    send_dir($rtoi(vx / len * 16384.0 + (vx >= 0.0 ? 0.5 : -0.5)),
             $rtoi(vy / len * 16384.0 + (vy >= 0.0 ? 0.5 : -0.5)),
             $rtoi(vz / len * 16384.0 + (vz >= 0.0 ? 0.5 : -0.5)));
  endtask

  initial begin
    int th;
    int pick;
    int x;
    th = int'(THRESH);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // axes, threshold boundary, zero-length tangent, non-unit extremes
    send_dir(16384, 0, 0);
    send_dir(-16384, 0, 0);
    send_dir(0, 16384, 0);
    send_dir(0, -16384, 0);
    hold_off(3);
    send_dir(0, 0, 16384);
    send_dir(0, 0, -16384);
    send_dir(0, 0, 0);
    send_dir(th - 1, 0, 0);
    send_dir(-(th - 1), 0, 0);
    send_dir(th, 0, 0);
    send_dir(-th, 0, 0);
    send_dir(th, th, th);
    send_dir(th - 1, th + 1, th + 1);
    hold_off(1);
    send_dir(32767, 32767, 32767);
    send_dir(-32768, -32768, -32768);
    send_dir(-32768, 0, 0);
    send_dir(0, -32768, 32767);
    send_dir(11585, 11585, 0);
    send_dir(0, 11585, -11585);
    send_dir(1, 0, 0);
    send_dir(0, 1, 0);
    send_dir(16384, 16384, 16384);
    drain();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_unit_dir();
      end else if (pick < 75) begin
        // straddle the branch threshold on x
        x = th + int'($urandom_range(6)) - 3;
        send_dir($urandom_range(1) ? x : -x, rand_comp(), rand_comp());
      end else if (pick < 85) begin
        // tangent may collapse to zero here
        send_dir(rand_comp(), 0, 0);
      end else begin
        send_dir(int'($urandom_range(65535)), int'($urandom_range(65535)),
                 int'($urandom_range(65535)));
      end
      if (n == RAND_ITEMS / 2) drain();
      else if (n < RAND_ITEMS - CALM_TAIL && $urandom_range(3) == 0)
        hold_off($urandom_range(1, 8));
    end

    start <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0 && frames_pending == 0)
      $display("[orthonormal_basis_from_direction_unit] OK");
    else
      $display("[orthonormal_basis_from_direction_unit] ERROR");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("[orthonormal_basis_from_direction_unit] ERROR");
    $finish;
  end

endmodule

[filelist.f]
sv/obd_pkg.sv
sv/obd_sqrt.sv
sv/obd_div.sv
sv/obd_cross.sv
sv/orthonormal_basis_from_direction_unit.sv
sim/obd_frame_checker.sv
sim/orthonormal_basis_from_direction_unit_tb.sv
